// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cpts_pkg.sv =====
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants of the counter priority thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

  localparam int CfgW     = 6;
  localparam int CfgIdxW  = 1;
  localparam int NewPrioW = 6;

  localparam logic [CfgW-1:0] DefaultPrioReset = 6'd20;
  localparam logic [CfgW-1:0] MaxPrioReset     = 6'd40;

  localparam logic [CfgIdxW-1:0] CfgIdxDefaultPrio = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxMaxPrio     = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_CREATE   = 2'd1,
    OP_KILL     = 2'd2,
    OP_SET_PRIO = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_ARG = 2'd2,
    ST_FATAL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_CMP    = 2'd0,
    ALU_RECALC = 2'd1,
    ALU_DEC    = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic prio;
    logic cnt;
    logic succ;
    logic use_set;
    logic use_clr;
  } tbl_we_t;

endpackage

`default_nettype wire

// ===== rtl/cpts_if.sv =====
// ----------------------------------------------------------------------------
// cpts_if
// Valid/ready channels of the scheduler: request, response and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpts_in_if #(
  parameter int SLOT_W = 4
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic                          user_mode;
  logic [SLOT_W-1:0]             slot;
  logic [cpts_pkg::NewPrioW-1:0] new_priority;

  modport source (output valid, output opcode, output user_mode, output slot,
                  output new_priority, input ready);
  modport sink (input valid, input opcode, input user_mode, input slot,
                input new_priority, output ready);
endinterface

interface cpts_out_if #(
  parameter int SLOT_W = 4
) ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] chosen_slot;
  logic              switched;
  logic              counter_negative;

  modport source (output valid, output status, output chosen_slot, output switched,
                  output counter_negative, input ready);
  modport sink (input valid, input status, input chosen_slot, input switched,
                input counter_negative, output ready);
endinterface

interface cpts_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [cpts_pkg::CfgIdxW-1:0] index;
  logic [cpts_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/counter_priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// counter_priority_thread_scheduler
// Thread table with a circular run ring and a counter/priority tick scheduler.
//
// Channels: in_if_i carries one operation (tick, create, kill, set priority),
// out_if_o returns exactly one result per operation, cfg_if_i writes the
// default and maximum priority registers and is always ready.
// One operation is in flight at a time; in_if_i.ready is high only while idle.
// Set priority, kernel tick, a rejected kill and a kill of slot 0 finish
// without a walk; a kill walks the ring to the victim's predecessor; a
// create scans for the first free slot and then links the thread; a user
// tick walks the ring once, and once more when all counters are recomputed.
// The rate is set by the ring walk through the table memory, one node per
// cycle, with the shared counter unit doing the compare or the recompute.
// Reset empties the table and the ring, makes slot 0 current and restores
// the configuration registers to 20 and 40.
// A stalled receiver holds the result in the output register; one more
// operation is taken and runs, then the block waits in its final state, not
// ready, until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_thread_scheduler #(
  parameter int THREAD_SLOTS  = 16,
  parameter int PRIORITY_BITS = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpts_in_if.sink      in_if_i,
  cpts_out_if.source   out_if_o,
  cpts_cfg_if.sink     cfg_if_i
);

  localparam int SlotW = $clog2(THREAD_SLOTS);
  localparam int NW    = $clog2(THREAD_SLOTS + 1);
  localparam int CntW  = PRIORITY_BITS + 2;

  localparam logic [SlotW:0]   SlotCnt  = (SlotW + 1)'(THREAD_SLOTS);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(THREAD_SLOTS - 1);
  localparam logic [NW-1:0]    StepMax  = NW'(THREAD_SLOTS);
  localparam logic [NW-1:0]    StepLast = NW'(THREAD_SLOTS - 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_WALK1    = 10'b0000000010,
    S_WALK2    = 10'b0000000100,
    S_TICK_FIN = 10'b0000001000,
    S_CR_SCAN  = 10'b0000010000,
    S_CR_LINK  = 10'b0000100000,
    S_CR_LINK2 = 10'b0001000000,
    S_KL_CAP   = 10'b0010000000,
    S_KL_WALK  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [SlotW-1:0]          cur_q, cur_d, ins_q, ins_d;
  logic [SlotW-1:0]          t_q, t_d, next_q, next_d, s_q, s_d, succ_s_q, succ_s_d;
  logic [NW-1:0]             n_q, n_d;
  logic signed [CntW-1:0]    best_q, best_d;
  logic [cpts_pkg::CfgW-1:0] dprio_q, mprio_q;

  cpts_pkg::status_e res_status_q, res_status_d, out_status_q, out_status_d;
  logic [SlotW-1:0]  res_chosen_q, res_chosen_d, out_chosen_q, out_chosen_d;
  logic              res_sw_q, res_sw_d, out_sw_q, out_sw_d;
  logic              res_neg_q, res_neg_d, out_neg_q, out_neg_d;
  logic              out_valid_q, out_valid_d;

  cpts_pkg::tbl_we_t         we;
  logic [SlotW-1:0]          wa, ra, wsucc;
  logic [PRIORITY_BITS-1:0]  wprio;
  logic signed [CntW-1:0]    wcnt;
  logic [PRIORITY_BITS-1:0]  rd_prio;
  logic signed [CntW-1:0]    rd_cnt;
  logic [SlotW-1:0]          rd_succ;
  logic [THREAD_SLOTS-1:0]   use_vec;

  cpts_pkg::alu_op_e         alu_op;
  logic signed [CntW-1:0]    alu_res;
  logic                      alu_gt;

  logic [SlotW-1:0]             in_slot;
  logic                         slot_ok, walk_stop, take;
  logic [PRIORITY_BITS-1:0]     dprio;

  assign in_slot   = in_if_i.slot;
  assign slot_ok   = {1'b0, in_slot} < SlotCnt;
  assign walk_stop = (n_q == StepMax) || (rd_succ == '0);
  assign take      = (n_q != '0) && use_vec[t_q] && alu_gt;
  assign dprio     = PRIORITY_BITS'(dprio_q);

  assign in_if_i.ready  = state_q == S_IDLE;
  assign cfg_if_i.ready = 1'b1;

  assign out_if_o.valid            = out_valid_q;
  assign out_if_o.status           = out_status_q;
  assign out_if_o.chosen_slot      = out_chosen_q;
  assign out_if_o.switched         = out_sw_q;
  assign out_if_o.counter_negative = out_neg_q;

  cpts_table #(
    .THREAD_SLOTS  (THREAD_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_cpts_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .wr_addr_i (wa),
    .wr_prio_i (wprio),
    .wr_cnt_i  (wcnt),
    .wr_succ_i (wsucc),
    .rd_addr_i (ra),
    .rd_prio_o (rd_prio),
    .rd_cnt_o  (rd_cnt),
    .rd_succ_o (rd_succ),
    .use_o     (use_vec)
  );

  cpts_alu #(
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_cpts_alu (
    .op_i   (alu_op),
    .cnt_i  (rd_cnt),
    .best_i (best_q),
    .prio_i (rd_prio),
    .res_o  (alu_res),
    .gt_o   (alu_gt)
  );

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    ins_d        = ins_q;
    t_d          = t_q;
    n_d          = n_q;
    best_d       = best_q;
    next_d       = next_q;
    s_d          = s_q;
    succ_s_d     = succ_s_q;
    res_status_d = res_status_q;
    res_chosen_d = res_chosen_q;
    res_sw_d     = res_sw_q;
    res_neg_d    = res_neg_q;
    out_status_d = out_status_q;
    out_chosen_d = out_chosen_q;
    out_sw_d     = out_sw_q;
    out_neg_d    = out_neg_q;
    out_valid_d  = out_valid_q && !out_if_o.ready;
    we           = '0;
    wa           = '0;
    ra           = '0;
    wprio        = '0;
    wcnt         = '0;
    wsucc        = '0;
    alu_op       = cpts_pkg::ALU_CMP;

    case (state_q)
      S_IDLE: begin
        if (in_if_i.valid) begin
          res_status_d = cpts_pkg::ST_OK;
          res_chosen_d = '0;
          res_sw_d     = 1'b0;
          res_neg_d    = 1'b0;
          state_d      = S_DONE;
          case (cpts_pkg::opcode_e'(in_if_i.opcode))
            cpts_pkg::OP_TICK: begin
              if (in_if_i.user_mode) begin
                ra      = '0;
                t_d     = '0;
                n_d     = '0;
                best_d  = '1;
                next_d  = '0;
                state_d = S_WALK1;
              end
            end
            cpts_pkg::OP_CREATE: begin
              t_d     = '0;
              state_d = S_CR_SCAN;
            end
            cpts_pkg::OP_KILL: begin
              if (!(slot_ok && use_vec[in_slot])) begin
                res_status_d = cpts_pkg::ST_BAD_ARG;
              end else begin
                we.use_clr = 1'b1;
                wa         = in_slot;
                if (in_slot != '0) begin
                  ra      = in_slot;
                  s_d     = in_slot;
                  state_d = S_KL_CAP;
                end
              end
            end
            cpts_pkg::OP_SET_PRIO: begin
              if (!slot_ok || (in_if_i.new_priority > mprio_q)) begin
                res_status_d = cpts_pkg::ST_BAD_ARG;
              end else begin
                we.prio = 1'b1;
                wa      = in_slot;
                wprio   = PRIORITY_BITS'(in_if_i.new_priority);
              end
            end
            default: begin
              res_status_d = cpts_pkg::ST_OK;
            end
          endcase
        end
      end

      S_WALK1: begin
        alu_op = cpts_pkg::ALU_CMP;
        if (take) begin
          best_d = rd_cnt;
          next_d = t_q;
        end
        if (!walk_stop) begin
          ra  = rd_succ;
          t_d = rd_succ;
          n_d = n_q + NW'(1);
        end else if (best_d == '0) begin
          ra      = '0;
          t_d     = '0;
          n_d     = '0;
          state_d = S_WALK2;
        end else begin
          ra      = next_d;
          state_d = S_TICK_FIN;
        end
      end

      S_WALK2: begin
        alu_op = cpts_pkg::ALU_RECALC;
        if (n_q != '0) begin
          we.cnt = 1'b1;
          wa     = t_q;
          wcnt   = alu_res;
        end
        if (!walk_stop) begin
          ra  = rd_succ;
          t_d = rd_succ;
          n_d = n_q + NW'(1);
        end else begin
          ra      = next_q;
          state_d = S_TICK_FIN;
        end
      end

      S_TICK_FIN: begin
        alu_op       = cpts_pkg::ALU_DEC;
        res_chosen_d = next_q;
        if (next_q != '0) begin
          we.cnt    = 1'b1;
          wa        = next_q;
          wcnt      = alu_res;
          res_neg_d = alu_res[CntW-1];
        end
        if (next_q == cur_q) begin
          if (!use_vec[cur_q]) begin
            res_status_d = cpts_pkg::ST_FATAL;
          end
        end else begin
          cur_d    = next_q;
          res_sw_d = 1'b1;
        end
        state_d = S_DONE;
      end

      S_CR_SCAN: begin
        if (!use_vec[t_q]) begin
          we.prio      = 1'b1;
          we.cnt       = 1'b1;
          we.use_set   = 1'b1;
          wa           = t_q;
          wprio        = dprio;
          wcnt         = $signed({{(CntW - PRIORITY_BITS){1'b0}}, dprio});
          cur_d        = t_q;
          res_chosen_d = t_q;
          if (t_q != '0) begin
            ra      = ins_q;
            state_d = S_CR_LINK;
          end else begin
            state_d = S_DONE;
          end
        end else if (t_q == SlotLast) begin
          res_status_d = cpts_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          t_d = t_q + SlotW'(1);
        end
      end

      S_CR_LINK: begin
        we.succ = 1'b1;
        wa      = t_q;
        wsucc   = rd_succ;
        state_d = S_CR_LINK2;
      end

      S_CR_LINK2: begin
        we.succ = 1'b1;
        wa      = ins_q;
        wsucc   = t_q;
        ins_d   = t_q;
        state_d = S_DONE;
      end

      S_KL_CAP: begin
        succ_s_d = rd_succ;
        ra       = '0;
        t_d      = '0;
        n_d      = '0;
        state_d  = S_KL_WALK;
      end

      S_KL_WALK: begin
        if (rd_succ == s_q) begin
          we.succ = 1'b1;
          wa      = t_q;
          wsucc   = succ_s_q;
          ins_d   = succ_s_q;
          state_d = S_DONE;
        end else if (n_q == StepLast) begin
          state_d = S_DONE;
        end else begin
          ra  = rd_succ;
          t_d = rd_succ;
          n_d = n_q + NW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_if_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_chosen_d = res_chosen_q;
          out_sw_d     = res_sw_q;
          out_neg_d    = res_neg_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      ins_q       <= '0;
      out_valid_q <= 1'b0;
      dprio_q     <= cpts_pkg::DefaultPrioReset;
      mprio_q     <= cpts_pkg::MaxPrioReset;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (cfg_if_i.valid) begin
        case (cfg_if_i.index)
          cpts_pkg::CfgIdxDefaultPrio: begin
            dprio_q <= cfg_if_i.data;
          end
          cpts_pkg::CfgIdxMaxPrio: begin
            mprio_q <= cfg_if_i.data;
          end
          default: begin
            mprio_q <= mprio_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q          <= t_d;
    n_q          <= n_d;
    best_q       <= best_d;
    next_q       <= next_d;
    s_q          <= s_d;
    succ_s_q     <= succ_s_d;
    res_status_q <= res_status_d;
    res_chosen_q <= res_chosen_d;
    res_sw_q     <= res_sw_d;
    res_neg_q    <= res_neg_d;
    out_status_q <= out_status_d;
    out_chosen_q <= out_chosen_d;
    out_sw_q     <= out_sw_d;
    out_neg_q    <= out_neg_d;
  end

endmodule

`default_nettype wire

// ===== rtl/cpts_alu.sv =====
// ----------------------------------------------------------------------------
// cpts_alu
// Shared counter unit: compare against best, recompute, saturating decrement.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_alu #(
  parameter int PRIORITY_BITS = 6,
  localparam int CntW = PRIORITY_BITS + 2
) (
  input  cpts_pkg::alu_op_e         op_i,
  input  logic signed [CntW-1:0]    cnt_i,
  input  logic signed [CntW-1:0]    best_i,
  input  logic [PRIORITY_BITS-1:0]  prio_i,
  output logic signed [CntW-1:0]    res_o,
  output logic                      gt_o
);

  logic signed [CntW:0] ext;
  logic signed [CntW:0] wide;

  assign ext  = $signed({cnt_i[CntW-1], cnt_i});
  assign gt_o = cnt_i > best_i;

  always_comb begin
    case (op_i)
      cpts_pkg::ALU_RECALC: begin
        wide = (ext >>> 1) + $signed({{(CntW + 1 - PRIORITY_BITS){1'b0}}, prio_i});
      end
      cpts_pkg::ALU_DEC: begin
        wide = ext + $signed({(CntW + 1){1'b1}});
      end
      default: begin
        wide = ext;
      end
    endcase
  end

  // saturate to the counter range
  always_comb begin
    if (wide[CntW] != wide[CntW-1]) begin
      res_o = wide[CntW] ? {1'b1, {(CntW - 1){1'b0}}} : {1'b0, {(CntW - 1){1'b1}}};
    end else begin
      res_o = wide[CntW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpts_table.sv =====
// ----------------------------------------------------------------------------
// cpts_table
// Thread table: priority, counter and ring successor memories with valid bits,
// plus the in-use flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_table #(
  parameter int THREAD_SLOTS  = 16,
  parameter int PRIORITY_BITS = 6,
  localparam int SlotW = $clog2(THREAD_SLOTS),
  localparam int CntW  = PRIORITY_BITS + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpts_pkg::tbl_we_t         we_i,
  input  logic [SlotW-1:0]          wr_addr_i,
  input  logic [PRIORITY_BITS-1:0]  wr_prio_i,
  input  logic signed [CntW-1:0]    wr_cnt_i,
  input  logic [SlotW-1:0]          wr_succ_i,
  input  logic [SlotW-1:0]          rd_addr_i,
  output logic [PRIORITY_BITS-1:0]  rd_prio_o,
  output logic signed [CntW-1:0]    rd_cnt_o,
  output logic [SlotW-1:0]          rd_succ_o,
  output logic [THREAD_SLOTS-1:0]   use_o
);

  logic [PRIORITY_BITS-1:0] prio_mem [THREAD_SLOTS];
  logic [CntW-1:0]          cnt_mem  [THREAD_SLOTS];
  logic [SlotW-1:0]         succ_mem [THREAD_SLOTS];

  logic [THREAD_SLOTS-1:0]  prio_vld_q, cnt_vld_q, succ_vld_q, use_q;
  logic [PRIORITY_BITS-1:0] prio_rd_q;
  logic [CntW-1:0]          cnt_rd_q;
  logic [SlotW-1:0]         succ_rd_q;
  logic                     prio_rv_q, cnt_rv_q, succ_rv_q;
  logic                     hit;

  assign hit = wr_addr_i == rd_addr_i;

  // write-first read ports
  always_ff @(posedge clk_i) begin
    if (we_i.prio) begin
      prio_mem[wr_addr_i] <= wr_prio_i;
    end
    if (we_i.cnt) begin
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    if (we_i.succ) begin
      succ_mem[wr_addr_i] <= wr_succ_i;
    end
    prio_rd_q <= (we_i.prio && hit) ? wr_prio_i : prio_mem[rd_addr_i];
    cnt_rd_q  <= (we_i.cnt && hit) ? wr_cnt_i : cnt_mem[rd_addr_i];
    succ_rd_q <= (we_i.succ && hit) ? wr_succ_i : succ_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_vld_q <= '0;
      cnt_vld_q  <= '0;
      succ_vld_q <= '0;
      use_q      <= '0;
      prio_rv_q  <= 1'b0;
      cnt_rv_q   <= 1'b0;
      succ_rv_q  <= 1'b0;
    end else begin
      if (we_i.prio) begin
        prio_vld_q[wr_addr_i] <= 1'b1;
      end
      if (we_i.cnt) begin
        cnt_vld_q[wr_addr_i] <= 1'b1;
      end
      if (we_i.succ) begin
        succ_vld_q[wr_addr_i] <= 1'b1;
      end
      if (we_i.use_set) begin
        use_q[wr_addr_i] <= 1'b1;
      end else if (we_i.use_clr) begin
        use_q[wr_addr_i] <= 1'b0;
      end
      prio_rv_q <= (we_i.prio && hit) || prio_vld_q[rd_addr_i];
      cnt_rv_q  <= (we_i.cnt && hit) || cnt_vld_q[rd_addr_i];
      succ_rv_q <= (we_i.succ && hit) || succ_vld_q[rd_addr_i];
    end
  end

  assign rd_prio_o = prio_rv_q ? prio_rd_q : '0;
  assign rd_cnt_o  = cnt_rv_q ? cnt_rd_q : '0;
  assign rd_succ_o = succ_rv_q ? succ_rd_q : '0;
  assign use_o     = use_q;

endmodule

`default_nettype wire

// ===== rtl/cpts_checker.sv =====
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpts_checker #(
  parameter int SLOT_W = 4
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [1:0]        status_i,
  input logic [SLOT_W-1:0] chosen_slot_i,
  input logic              switched_i,
  input logic              counter_negative_i
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(chosen_slot_i), "result dropped or changed while stalled")
  `ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "second request taken while busy")
  `ASSERT_IMPLIES(a_full_fields, clk_i, rst_ni, out_valid_i && (status_i == cpts_pkg::ST_FULL), (chosen_slot_i == '0) && !switched_i && !counter_negative_i, "full table result carries a slot")
  `ASSERT_IMPLIES(a_switch_ok, clk_i, rst_ni, out_valid_i && switched_i, status_i == cpts_pkg::ST_OK, "switch reported with an error status")
  `ASSERT_IMPLIES(a_neg_slot, clk_i, rst_ni, out_valid_i && counter_negative_i, chosen_slot_i != '0, "negative counter on the idle slot")

endmodule

bind counter_priority_thread_scheduler cpts_checker #(
  .SLOT_W ($clog2(THREAD_SLOTS))
) u_cpts_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_if_i.valid),
  .in_ready_i         (in_if_i.ready),
  .out_valid_i        (out_if_o.valid),
  .out_ready_i        (out_if_o.ready),
  .status_i           (out_if_o.status),
  .chosen_slot_i      (out_if_o.chosen_slot),
  .switched_i         (out_if_o.switched),
  .counter_negative_i (out_if_o.counter_negative)
);

`default_nettype wire

// ===== sim/counter_priority_thread_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// counter_priority_thread_scheduler_tb
// Self-checking testbench of the counter priority thread scheduler. Directed
// operations on an empty and a full table, then random operation mixes under
// several default/maximum priority settings, with random idling on both
// channels and one long hold-off of the result channel. Every result is
// checked against a cycle-free model of the thread table and run ring.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_thread_scheduler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots    = 16;
  localparam int CountMax = 127;
  localparam int CountMin = -128;

  typedef struct packed {
    cpts_pkg::status_e status;
    logic [3:0]        chosen_slot;
    logic              switched;
    logic              counter_negative;
  } sched_result_t;

  logic clk_i;
  logic rst_ni;

  cpts_in_if  #(.SLOT_W(4)) in_if ();
  cpts_out_if #(.SLOT_W(4)) out_if ();
  cpts_cfg_if               cfg_if ();

  counter_priority_thread_scheduler #(
    .THREAD_SLOTS  (Slots),
    .PRIORITY_BITS (6)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if_i  (in_if),
    .out_if_o (out_if),
    .cfg_if_i (cfg_if)
  );

  // thread table mirror
  logic [5:0] dflt_prio_m;
  logic [5:0] max_prio_m;
  bit         live_m [Slots];
  logic [5:0] prio_m [Slots];
  int         count_m [Slots];
  logic [3:0] succ_m [Slots];
  logic [3:0] current_m;
  logic [3:0] insert_m;

  sched_result_t outcome_q [$];
  sched_result_t want;
  int            mismatches;
  bit            idle_en;
  int            hold_off_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int clamp_count(int v);
    if (v > CountMax) return CountMax;
    if (v < CountMin) return CountMin;
    return v;
  endfunction

  function automatic sched_result_t apply_op(cpts_pkg::opcode_e op, bit um, logic [3:0] s,
                                             logic [5:0] np);
    sched_result_t r;
    int            best;
    logic [3:0]    t;
    logic [3:0]    pick;
    int            i;
    bit            found;
    r = '{status: cpts_pkg::ST_OK, chosen_slot: 4'd0, switched: 1'b0,
          counter_negative: 1'b0};
    case (op)
      cpts_pkg::OP_TICK: begin
        if (um) begin
          best = -1;
          t    = 4'd0;
          pick = 4'd0;
          for (int n = 0; n < Slots; n++) begin
            t = succ_m[t];
            if (t == 4'd0) break;
            if (live_m[t] && count_m[t] > best) begin
              best = count_m[t];
              pick = t;
            end
          end
          if (best == 0) begin
            t = 4'd0;
            for (int n = 0; n < Slots; n++) begin
              t = succ_m[t];
              if (t == 4'd0) break;
              count_m[t] = clamp_count((count_m[t] >>> 1) + int'(prio_m[t]));
            end
          end
          r.chosen_slot = pick;
          if (pick != 4'd0) begin
            count_m[pick] = clamp_count(count_m[pick] - 1);
            r.counter_negative = count_m[pick] < 0;
          end
          if (pick == current_m) begin
            if (!live_m[current_m]) r.status = cpts_pkg::ST_FATAL;
          end else begin
            current_m  = pick;
            r.switched = 1'b1;
          end
        end
      end
      cpts_pkg::OP_CREATE: begin
        found = 1'b0;
        i     = 0;
        for (int n = 0; n < Slots; n++) begin
          if (!live_m[n]) begin
            found = 1'b1;
            i     = n;
            break;
          end
        end
        if (!found) begin
          r.status = cpts_pkg::ST_FULL;
        end else begin
          live_m[i]  = 1'b1;
          prio_m[i]  = dflt_prio_m;
          count_m[i] = int'(dflt_prio_m);
          if (i != 0) begin
            succ_m[i]        = succ_m[insert_m];
            succ_m[insert_m] = i[3:0];
            insert_m         = i[3:0];
          end
          current_m     = i[3:0];
          r.chosen_slot = i[3:0];
        end
      end
      cpts_pkg::OP_KILL: begin
        if (!live_m[s]) begin
          r.status = cpts_pkg::ST_BAD_ARG;
        end else begin
          live_m[s] = 1'b0;
          if (s != 4'd0) begin
            t = 4'd0;
            for (int n = 0; n < Slots; n++) begin
              if (succ_m[t] == s) begin
                succ_m[t] = succ_m[s];
                insert_m  = succ_m[t];
                break;
              end
              t = succ_m[t];
            end
          end
        end
      end
      default: begin
        if (np > max_prio_m) r.status = cpts_pkg::ST_BAD_ARG;
        else prio_m[s] = np;
      end
    endcase
    return r;
  endfunction

  task automatic send_op(cpts_pkg::opcode_e op, bit um, logic [3:0] s, logic [5:0] np);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap          = $urandom_range(1, 14);
      in_if.valid  = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.opcode       = op;
    in_if.user_mode    = um;
    in_if.slot         = s;
    in_if.new_priority = np;
    do @(posedge clk_i); while (!in_if.ready);
    outcome_q.push_back(apply_op(op, um, s, np));
    @(negedge clk_i);
  endtask

  // drop the request and wait for every outstanding result
  task automatic settle();
    in_if.valid = 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_priorities(logic [5:0] dflt, logic [5:0] maxp);
    settle();
    for (int k = 0; k < 2; k++) begin
      cfg_if.valid = 1'b1;
      cfg_if.index = (k == 0) ? cpts_pkg::CfgIdxDefaultPrio : cpts_pkg::CfgIdxMaxPrio;
      cfg_if.data  = (k == 0) ? dflt : maxp;
      do @(posedge clk_i); while (!cfg_if.ready);
      if (k == 0) dflt_prio_m = dflt;
      else max_prio_m = maxp;
      @(negedge clk_i);
    end
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_random(int count, int create_pct, int kill_pct);
    int         r;
    logic [3:0] live_slots [$];
    logic [3:0] s;
    logic [5:0] np;
    for (int k = 0; k < count; k++) begin
      r  = $urandom_range(0, 99);
      s  = 4'($urandom_range(0, 15));
      np = 6'($urandom_range(0, 63));
      if (r < 40) begin
        send_op(cpts_pkg::OP_TICK, $urandom_range(0, 9) != 0, s, np);
      end else if (r < 40 + create_pct) begin
        send_op(cpts_pkg::OP_CREATE, 1'($urandom_range(0, 1)), s, np);
      end else if (r < 40 + create_pct + kill_pct) begin
        live_slots.delete();
        for (int n = 0; n < Slots; n++) if (live_m[n]) live_slots.push_back(n[3:0]);
        if (live_slots.size() != 0 && $urandom_range(0, 4) != 0)
          s = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_op(cpts_pkg::OP_KILL, 1'($urandom_range(0, 1)), s, np);
      end else begin
        if ($urandom_range(0, 3) != 0) np = 6'($urandom_range(0, max_prio_m));
        send_op(cpts_pkg::OP_SET_PRIO, 1'($urandom_range(0, 1)), s, np);
      end
    end
  endtask

  task automatic test_empty_table();
    send_op(cpts_pkg::OP_TICK, 1'b1, 4'd0, 6'd0);
    send_op(cpts_pkg::OP_TICK, 1'b0, 4'd15, 6'd63);
    send_op(cpts_pkg::OP_KILL, 1'b0, 4'd9, 6'd0);
    send_op(cpts_pkg::OP_SET_PRIO, 1'b0, 4'd15, 6'd63);
    send_op(cpts_pkg::OP_SET_PRIO, 1'b1, 4'd7, 6'd0);
  endtask

  task automatic test_fill_and_kill();
    repeat (Slots + 1) send_op(cpts_pkg::OP_CREATE, 1'b0, 4'd0, 6'd0);
    send_op(cpts_pkg::OP_KILL, 1'b0, 4'd0, 6'd0);
    send_op(cpts_pkg::OP_KILL, 1'b0, 4'd0, 6'd0);
    send_op(cpts_pkg::OP_TICK, 1'b1, 4'd0, 6'd0);
  endtask

  task automatic test_default_priorities();
    run_random(200, 20, 15);
  endtask

  task automatic test_zero_priorities();
    set_priorities(6'd0, 6'd0);
    run_random(150, 15, 15);
  endtask

  task automatic test_output_backpressure();
    settle();
    hold_off_cycles = 300;
    run_random(12, 20, 15);
  endtask

  task automatic test_max_priorities();
    set_priorities(6'd63, 6'd63);
    run_random(150, 20, 15);
  endtask

  task automatic test_kill_heavy();
    set_priorities(6'd1, 6'd63);
    run_random(150, 15, 25);
  endtask

  task automatic test_random_priorities();
    set_priorities(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    run_random(100, 20, 15);
  endtask

  task automatic test_no_idling();
    settle();
    idle_en = 1'b0;
    set_priorities(cpts_pkg::DefaultPrioReset, cpts_pkg::MaxPrioReset);
    run_random(100, 20, 15);
  endtask

  initial begin : rx_ready_gen
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 14) - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d switched %0b negative %0b",
                   out_if.status, out_if.chosen_slot, out_if.switched,
                   out_if.counter_negative);
      end else begin
        want = outcome_q.pop_front();
        if (out_if.status !== want.status || out_if.chosen_slot !== want.chosen_slot ||
            out_if.switched !== want.switched ||
            out_if.counter_negative !== want.counter_negative) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: status %0d/%0d slot %0d/%0d switched %0b/%0b",
                      " negative %0b/%0b (expected/actual)"},
                     $realtime, want.status, out_if.status, want.chosen_slot,
                     out_if.chosen_slot, want.switched, out_if.switched,
                     want.counter_negative, out_if.counter_negative);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("counter_priority_thread_scheduler_tb failed");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = cpts_pkg::OP_TICK;
    in_if.user_mode    = 1'b0;
    in_if.slot         = '0;
    in_if.new_priority = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = cpts_pkg::CfgIdxDefaultPrio;
    cfg_if.data        = '0;
    mismatches         = 0;
    idle_en            = 1'b1;
    hold_off_cycles    = 0;
    dflt_prio_m        = cpts_pkg::DefaultPrioReset;
    max_prio_m         = cpts_pkg::MaxPrioReset;
    current_m          = 4'd0;
    insert_m           = 4'd0;
    for (int n = 0; n < Slots; n++) begin
      live_m[n]  = 1'b0;
      prio_m[n]  = 6'd0;
      count_m[n] = 0;
      succ_m[n]  = 4'd0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_fill_and_kill();
    test_default_priorities();
    test_zero_priorities();
    test_output_backpressure();
    test_max_priorities();
    test_kill_heavy();
    test_random_priorities();
    test_no_idling();

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("counter_priority_thread_scheduler_tb passed");
    end else begin
      $display("counter_priority_thread_scheduler_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/cpts_pkg.sv
rtl/cpts_if.sv
rtl/cpts_alu.sv
rtl/cpts_table.sv
rtl/counter_priority_thread_scheduler.sv
rtl/cpts_checker.sv
sim/counter_priority_thread_scheduler_tb.sv
